// File: rtl/face_node_set_match_lookup_core_macros.svh
// Assertion macros for the face node-set match lookup block.
// Used by the top level; needs nothing else.
`ifndef FACE_NODE_SET_MATCH_LOOKUP_CORE_MACROS_SVH
`define FACE_NODE_SET_MATCH_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FNSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("face_node_set_match_lookup_core: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define FNSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("face_node_set_match_lookup_core: next-cycle check failed");

`endif

// File: rtl/fnsm_pkg.sv
// Shared types and constants of the face node-set match lookup block.
// No dependencies; used by fnsm_tables and the top level.
package fnsm_pkg;

   // Parameter defaults
   localparam int MAX_FACES_DEF      = 1024;
   localparam int NODES_PER_FACE_DEF = 4;
   localparam int MAX_STEPS_DEF      = 64;

   // Fixed field widths
   localparam int ID_W         = 32;
   localparam int ROW_W        = 10;
   localparam int STEP_W       = 16;
   localparam int VALUE_W      = 32;
   localparam int FACE_COUNT_W = 11;
   localparam int LAST_STEP_W  = 17;
   localparam int SLOT_MAX     = 4;
   localparam int CSR_AW       = 4;
   localparam int CSR_DW       = 32;

   // Operation codes
   localparam logic [1:0] OP_LOAD_IDS   = 2'd0;
   localparam logic [1:0] OP_LOAD_VALUE = 2'd1;
   localparam logic [1:0] OP_BEGIN_STEP = 2'd2;
   localparam logic [1:0] OP_QUERY      = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_APPLIED  = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_SKIPPED  = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_FACE_COUNT  = 2'd0;
   localparam logic [1:0] REG_START_STEP  = 2'd1;
   localparam logic [1:0] REG_TABLE_READY = 2'd2;

   typedef struct packed {
      logic [1:0]                op;
      logic [ROW_W-1:0]          row;
      logic signed [ID_W-1:0]    id_0;
      logic signed [ID_W-1:0]    id_1;
      logic signed [ID_W-1:0]    id_2;
      logic signed [ID_W-1:0]    id_3;
      logic [STEP_W-1:0]         step;
      logic signed [VALUE_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] face_value;
      logic [ROW_W-1:0]          matched_row;
      logic [1:0]                status;
   } rsp_type;

   // Table port strobes from the sequencer
   typedef struct packed {
      logic id_we;
      logic id_re;
      logic val_we;
      logic val_re;
   } tbl_ctl_type;

endpackage

// File: rtl/fnsm_tables.sv
// Id and value tables of the face lookup, with the row match compare.
// Depends on fnsm_pkg.
module fnsm_tables #(
   parameter int MAX_FACES      = fnsm_pkg::MAX_FACES_DEF,
   parameter int NODES_PER_FACE = fnsm_pkg::NODES_PER_FACE_DEF,
   parameter int MAX_STEPS      = fnsm_pkg::MAX_STEPS_DEF,
   localparam int ROW_AW    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1,
   localparam int VAL_DEPTH = MAX_FACES * (MAX_STEPS + 1),
   localparam int VAL_AW    = $clog2(VAL_DEPTH),
   localparam int SLOT_W    = NODES_PER_FACE * fnsm_pkg::ID_W,
   localparam int VALUE_W   = fnsm_pkg::VALUE_W
) (
   input  logic                      clock,
   input  fnsm_pkg::tbl_ctl_type     ctl,
   input  logic [ROW_AW-1:0]         id_addr,
   input  logic [SLOT_W-1:0]         id_wdata,
   input  logic [SLOT_W-1:0]         qry_ids,
   output logic                      id_hit,
   input  logic [VAL_AW-1:0]         val_addr,
   input  logic signed [VALUE_W-1:0] val_wdata,
   output logic signed [VALUE_W-1:0] val_rdata
);

   localparam int ID_W = fnsm_pkg::ID_W;

   logic [SLOT_W-1:0]         id_mem [MAX_FACES];
   logic signed [VALUE_W-1:0] val_mem [VAL_DEPTH];

   logic [SLOT_W-1:0]         id_rdata_ff;
   logic signed [VALUE_W-1:0] val_rdata_ff;
   logic [NODES_PER_FACE-1:0] slot_found;

   always_ff @(posedge clock) begin
      if (ctl.id_we) begin
         id_mem[id_addr] <= id_wdata;
      end
      if (ctl.id_re) begin
         id_rdata_ff <= id_mem[id_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         val_mem[val_addr] <= val_wdata;
      end
      if (ctl.val_re) begin
         val_rdata_ff <= val_mem[val_addr];
      end
   end

   // every stored id must occur somewhere among the query ids
   always_comb begin
      for (int i = 0; i < NODES_PER_FACE; i++) begin
         slot_found[i] = 1'b0;
         for (int j = 0; j < NODES_PER_FACE; j++) begin
            if (qry_ids[j*ID_W +: ID_W] == id_rdata_ff[i*ID_W +: ID_W]) begin
               slot_found[i] = 1'b1;
            end
         end
      end
   end

   assign id_hit    = &slot_found;
   assign val_rdata = val_rdata_ff;

endmodule

// File: rtl/face_node_set_match_lookup_core.sv
// Top level of the face node-set match lookup: sequencer, step state, CSRs.
// Depends on fnsm_pkg, fnsm_tables and face_node_set_match_lookup_core_macros.svh.
//
//   channel  | ports                    | direction | moves
//   ---------+--------------------------+-----------+---------------------------------
//   request  | req_valid/ready/data     | in        | loads, begin step, face queries
//   response | rsp_valid/ready/data     | out       | one result per face query
//   csr      | csr_psel..csr_pready     | in/out    | face_count, start_step, table_ready
//
// Loads and begin step need no further work: the transfer writes the table or step state.
// A query in an open pass scans from the search start to the first match: the id
// table has one read port, so the scan examines one row per cycle, then one value read.
// A query with no match scans to the row limit and returns a no-match result.
// Reset is synchronous; no table clearing, so the block is ready right after reset.
// A result waits in the output register while the next request transfer is taken;
// a stalled response only holds the sequencer once a second query result is ready.
`include "face_node_set_match_lookup_core_macros.svh"

module face_node_set_match_lookup_core #(
   parameter int MAX_FACES      = fnsm_pkg::MAX_FACES_DEF,
   parameter int NODES_PER_FACE = fnsm_pkg::NODES_PER_FACE_DEF,
   parameter int MAX_STEPS      = fnsm_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fnsm_pkg::req_type             req_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fnsm_pkg::rsp_type             rsp_data,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fnsm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fnsm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fnsm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int ID_W         = fnsm_pkg::ID_W;
   localparam int ROW_W        = fnsm_pkg::ROW_W;
   localparam int STEP_W       = fnsm_pkg::STEP_W;
   localparam int FACE_COUNT_W = fnsm_pkg::FACE_COUNT_W;
   localparam int LAST_STEP_W  = fnsm_pkg::LAST_STEP_W;
   localparam int CSR_AW       = fnsm_pkg::CSR_AW;
   localparam int CSR_DW       = fnsm_pkg::CSR_DW;
   localparam int COLS         = MAX_STEPS + 1;
   localparam int COL_W        = $clog2(COLS);
   localparam int ROW_AW       = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int VAL_AW       = $clog2(MAX_FACES * COLS);
   localparam int SLOT_W       = NODES_PER_FACE * ID_W;
   localparam int FACES_W      = $clog2(MAX_FACES + 1);
   localparam int LIM_W        = (FACE_COUNT_W > FACES_W) ? FACE_COUNT_W : FACES_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_VWAIT,
      ST_DONE
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type                      state_ff, state_in;
   logic [FACE_COUNT_W-1:0]        face_count_ff;
   logic [STEP_W-1:0]              start_step_ff;
   logic                           table_ready_ff;

   logic signed [LAST_STEP_W-1:0]  last_step_ff, last_step_in;
   logic [LIM_W-1:0]               search_start_ff, search_start_in;
   logic                           pass_active_ff, pass_active_in;
   logic [COL_W-1:0]               value_column_ff, value_column_in;

   logic [LIM_W-1:0]               issue_ptr_ff, issue_ptr_in;
   logic                           chk_vld_ff, chk_vld_in;
   logic [ROW_AW-1:0]              chk_row_ff, chk_row_in;
   logic [SLOT_W-1:0]              qry_ids_ff, qry_ids_in;
   fnsm_pkg::rsp_type              res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fnsm_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- datapath wires
   fnsm_pkg::tbl_ctl_type          tbl_ctl;
   logic [ROW_AW-1:0]              id_addr;
   logic [VAL_AW-1:0]              val_addr;
   logic                           id_hit;
   logic signed [ID_W-1:0]         val_rdata;

   logic [fnsm_pkg::SLOT_MAX-1:0][ID_W-1:0] req_id_slots;
   logic [SLOT_W-1:0]              req_ids;
   logic [ROW_AW-1:0]              load_row;
   logic [VAL_AW-1:0]              load_addr;
   logic [VAL_AW-1:0]              scan_addr;
   logic                           row_in_range;
   logic                           col_in_range;
   logic signed [LAST_STEP_W-1:0]  step_s;
   logic [STEP_W-1:0]              step_diff;
   logic [LIM_W-1:0]               scan_limit;
   logic [1:0]                     csr_idx;
   logic                           csr_wr;

   // ---------------------------------------------------------------- tables
   fnsm_tables #(
      .MAX_FACES      (MAX_FACES),
      .NODES_PER_FACE (NODES_PER_FACE),
      .MAX_STEPS      (MAX_STEPS)
   ) u_tables (
      .clock     (clock),
      .ctl       (tbl_ctl),
      .id_addr   (id_addr),
      .id_wdata  (req_ids),
      .qry_ids   (qry_ids_ff),
      .id_hit    (id_hit),
      .val_addr  (val_addr),
      .val_wdata (req_data.load_value),
      .val_rdata (val_rdata)
   );

   // ---------------------------------------------------------------- request decode
   assign req_id_slots = {req_data.id_3, req_data.id_2, req_data.id_1, req_data.id_0};

   // keep only the slots a face row actually has
   always_comb begin
      for (int k = 0; k < NODES_PER_FACE; k++) begin
         req_ids[k*ID_W +: ID_W] = req_id_slots[k];
      end
   end

   assign load_row     = ROW_AW'(req_data.row);
   assign load_addr    = VAL_AW'(VAL_AW'(load_row) * VAL_AW'(COLS)
                                 + VAL_AW'(req_data.step));
   assign scan_addr    = VAL_AW'(VAL_AW'(chk_row_ff) * VAL_AW'(COLS)
                                 + VAL_AW'(value_column_ff));
   assign row_in_range = int'(req_data.row) < MAX_FACES;
   assign col_in_range = int'(req_data.step) <= MAX_STEPS;
   assign step_s       = $signed({1'b0, req_data.step});
   assign step_diff    = req_data.step - start_step_ff;

   // clamp the scan to the table depth
   assign scan_limit = (int'(face_count_ff) > MAX_FACES) ? LIM_W'(MAX_FACES)
                                                          : LIM_W'(face_count_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in        = state_ff;
      last_step_in    = last_step_ff;
      search_start_in = search_start_ff;
      pass_active_in  = pass_active_ff;
      value_column_in = value_column_ff;
      issue_ptr_in    = issue_ptr_ff;
      chk_vld_in      = chk_vld_ff;
      chk_row_in      = chk_row_ff;
      qry_ids_in      = qry_ids_ff;
      res_in          = res_ff;
      rsp_data_in     = rsp_data_ff;
      // drop the response once it is taken
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      tbl_ctl         = '0;
      id_addr         = load_row;
      val_addr        = load_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.op)
                  fnsm_pkg::OP_LOAD_IDS: begin
                     tbl_ctl.id_we = row_in_range;
                  end
                  fnsm_pkg::OP_LOAD_VALUE: begin
                     tbl_ctl.val_we = row_in_range && col_in_range;
                  end
                  fnsm_pkg::OP_BEGIN_STEP: begin
                     // any begin step closes the pass; only a newer step may reopen it
                     pass_active_in = 1'b0;
                     if (step_s > last_step_ff) begin
                        if (table_ready_ff) begin
                           last_step_in    = step_s;
                           search_start_in = '0;
                           if (req_data.step >= start_step_ff
                               && int'(step_diff) <= MAX_STEPS) begin
                              value_column_in = COL_W'(step_diff);
                              pass_active_in  = 1'b1;
                           end
                        end else begin
                           last_step_in = step_s - LAST_STEP_W'(1);
                        end
                     end
                  end
                  fnsm_pkg::OP_QUERY: begin
                     qry_ids_in = req_ids;
                     if (!pass_active_ff) begin
                        res_in.face_value  = '0;
                        res_in.matched_row = '0;
                        res_in.status      = fnsm_pkg::STATUS_SKIPPED;
                        state_in           = ST_DONE;
                     end else begin
                        issue_ptr_in = search_start_ff;
                        chk_vld_in   = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            if (chk_vld_ff && id_hit) begin
               // first match found: fetch its value, stop issuing rows
               tbl_ctl.val_re = 1'b1;
               val_addr       = scan_addr;
               chk_vld_in     = 1'b0;
               state_in       = ST_VWAIT;
            end else if (issue_ptr_ff < scan_limit) begin
               // read the next row while the previous one is compared
               tbl_ctl.id_re = 1'b1;
               id_addr       = ROW_AW'(issue_ptr_ff);
               chk_vld_in    = 1'b1;
               chk_row_in    = ROW_AW'(issue_ptr_ff);
               issue_ptr_in  = issue_ptr_ff + LIM_W'(1);
            end else if (chk_vld_ff) begin
               chk_vld_in = 1'b0;
            end else begin
               res_in.face_value  = '0;
               res_in.matched_row = '0;
               res_in.status      = fnsm_pkg::STATUS_NO_MATCH;
               state_in           = ST_DONE;
            end
         end

         ST_VWAIT: begin
            res_in.face_value  = val_rdata;
            res_in.matched_row = ROW_W'(chk_row_ff);
            res_in.status      = fnsm_pkg::STATUS_APPLIED;
            // advance the start only when the match sat right at it
            if (LIM_W'(chk_row_ff) == search_start_ff) begin
               search_start_in = search_start_ff + LIM_W'(1);
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         last_step_ff    <= -LAST_STEP_W'(1);
         search_start_ff <= '0;
         pass_active_ff  <= 1'b0;
         value_column_ff <= '0;
         issue_ptr_ff    <= '0;
         chk_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_step_ff    <= last_step_in;
         search_start_ff <= search_start_in;
         pass_active_ff  <= pass_active_in;
         value_column_ff <= value_column_in;
         issue_ptr_ff    <= issue_ptr_in;
         chk_vld_ff      <= chk_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      chk_row_ff  <= chk_row_in;
      qry_ids_ff  <= qry_ids_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- registers port
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_count_ff  <= '0;
         start_step_ff  <= '0;
         table_ready_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            fnsm_pkg::REG_FACE_COUNT:  face_count_ff  <= csr_pwdata[FACE_COUNT_W-1:0];
            fnsm_pkg::REG_START_STEP:  start_step_ff  <= csr_pwdata[STEP_W-1:0];
            fnsm_pkg::REG_TABLE_READY: table_ready_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         fnsm_pkg::REG_FACE_COUNT:  csr_prdata = CSR_DW'(face_count_ff);
         fnsm_pkg::REG_START_STEP:  csr_prdata = CSR_DW'(start_step_ff);
         fnsm_pkg::REG_TABLE_READY: csr_prdata = CSR_DW'(table_ready_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- assertions
   // a row under compare was issued below the scan limit
   `FNSM_ASSERT_IMPLY(a_scan_row_in_limit, clock, reset, (state_ff == ST_SCAN) && chk_vld_ff, LIM_W'(chk_row_ff) < scan_limit)
   // a value read always ends in an applied result
   `FNSM_ASSERT_NEXT(a_value_read_applied, clock, reset, state_ff == ST_VWAIT, (state_ff == ST_DONE) && (res_ff.status == fnsm_pkg::STATUS_APPLIED))
   // a query while the pass is closed goes straight to a skipped result
   `FNSM_ASSERT_NEXT(a_closed_query_skipped, clock, reset, req_valid && req_ready && (req_data.op == fnsm_pkg::OP_QUERY) && !pass_active_ff, (state_ff == ST_DONE) && (res_ff.status == fnsm_pkg::STATUS_SKIPPED))

endmodule

// File: bench/face_node_set_match_lookup_core_tb.sv
// Self-checking bench for face_node_set_match_lookup_core: loads, begin-step and query traffic
// checked against an in-bench model of the face table. Needs fnsm_pkg and the core RTL.
module face_node_set_match_lookup_core_tb;
   import fnsm_pkg::*;

   localparam int FACES = MAX_FACES_DEF;
   localparam int NODES = NODES_PER_FACE_DEF;
   localparam int STEPS = MAX_STEPS_DEF;
   localparam int ITEM_GOAL = 1425;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES = 400;
   localparam logic [ID_W-1:0] UNUSED_SLOT = '1;

   typedef logic [NODES-1:0][ID_W-1:0] id_set_type;

   // DUT ports; every input starts at a known value
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Items waiting to go out and lookup results the block still owes
   req_type face_items [$];
   rsp_type face_results_due [$];

   // Model of the block: table contents, step state and register shadows
   id_set_type          model_ids [FACES];
   logic [VALUE_W-1:0]  model_values [FACES][STEPS+1];
   int                  last_seen_step = -1;
   logic [FACE_COUNT_W-1:0] scan_start = '0;
   bit                  pass_open = 1'b0;
   logic [6:0]          cur_column = '0;
   logic [FACE_COUNT_W-1:0] cfg_face_count = '0;
   logic [STEP_W-1:0]   cfg_start_step = '0;
   bit                  cfg_table_ready = 1'b0;

   // Generator's copy of the id rows it loaded, used to build matching queries
   id_set_type gen_rows [FACES];

   int  gen_count = 0;
   int  transfers = 0;
   int  checked = 0;
   int  hits = 0;
   int  misses = 0;
   int  skips = 0;
   int  mismatches = 0;
   int  phase = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_request = 1'b0;
   logic rsp_hold = 1'b0;

   face_node_set_match_lookup_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one accepted item to the model; a query leaves one expected result behind.
   function automatic void apply_face_item(input req_type it);
      id_set_type q;
      id_set_type stored;
      rsp_type res;
      int s;
      int lim;
      int r;
      bit hit;
      bit all_found;
      bit found;
      q = {it.id_3, it.id_2, it.id_1, it.id_0};
      case (it.op)
         OP_LOAD_IDS: begin
            model_ids[it.row] = q;
         end
         OP_LOAD_VALUE: begin
            // columns past the last step are dropped
            if (it.step <= STEPS) model_values[it.row][it.step] = it.load_value;
         end
         OP_BEGIN_STEP: begin
            s = int'(it.step);
            pass_open = 1'b0;
            if (s > last_seen_step) begin
               if (cfg_table_ready) begin
                  last_seen_step = s;
                  scan_start = '0;
                  if (it.step >= cfg_start_step && int'(it.step - cfg_start_step) <= STEPS) begin
                     cur_column = 7'(it.step - cfg_start_step);
                     pass_open = 1'b1;
                  end
               end else begin
                  last_seen_step = s - 1;
               end
            end
         end
         OP_QUERY: begin
            res = '0;
            if (!pass_open) begin
               res.status = STATUS_SKIPPED;
            end else begin
               // clamp the scan to the table size
               lim = (int'(cfg_face_count) < FACES) ? int'(cfg_face_count) : FACES;
               hit = 1'b0;
               for (r = int'(scan_start); r < lim && !hit; r++) begin
                  stored = model_ids[r];
                  all_found = 1'b1;
                  for (int i = 0; i < NODES; i++) begin
                     found = 1'b0;
                     for (int j = 0; j < NODES; j++) begin
                        if (q[j] == stored[i]) found = 1'b1;
                     end
                     if (!found) all_found = 1'b0;
                  end
                  if (all_found) begin
                     hit = 1'b1;
                     res.face_value = model_values[r][cur_column];
                     res.matched_row = ROW_W'(r);
                     res.status = STATUS_APPLIED;
                     // advance only when the hit sits at the search start
                     if (r == int'(scan_start)) scan_start = scan_start + 1'b1;
                  end
               end
               if (!hit) res.status = STATUS_NO_MATCH;
            end
            face_results_due.push_back(res);
         end
      endcase
   endfunction

   function automatic void check_face_result(input rsp_type got);
      rsp_type want;
      if (face_results_due.size() == 0) begin
         $error("unexpected result: face_value %0d matched_row %0d status %0d",
                got.face_value, got.matched_row, got.status);
         mismatches++;
         return;
      end
      want = face_results_due.pop_front();
      checked++;
      case (want.status)
         STATUS_APPLIED:  hits++;
         STATUS_NO_MATCH: misses++;
         default:         skips++;
      endcase
      if (got.face_value !== want.face_value) begin
         $error("face_value expected %0d got %0d", want.face_value, got.face_value);
         mismatches++;
      end
      if (got.matched_row !== want.matched_row) begin
         $error("matched_row expected %0d got %0d", want.matched_row, got.matched_row);
         mismatches++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0d got %0d", want.status, got.status);
         mismatches++;
      end
   endfunction

   // Driver: offer the next pending item, hold it until the transfer, idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (face_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= face_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random, and drop ready entirely during the hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Hold-off: once asked, refuse results long enough for the block to back up its input.
   initial begin
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Monitor: check results first so a same-edge request never feeds this edge's result.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_face_result(rsp_data);
         if (req_valid && req_ready) begin
            apply_face_item(req_data);
            transfers++;
         end
      end
   end

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      // the write lands at this edge
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_FACE_COUNT:  cfg_face_count = value[FACE_COUNT_W-1:0];
         REG_START_STEP:  cfg_start_step = value[STEP_W-1:0];
         REG_TABLE_READY: cfg_table_ready = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input int fc, input int start, input bit ready);
      write_register(REG_FACE_COUNT, 32'(fc));
      write_register(REG_START_STEP, 32'(start));
      write_register(REG_TABLE_READY, {31'd0, ready});
      @(negedge clock);
   endtask

   // Wait for every item to go out and every result to come back, then let the block go quiet.
   task automatic settle();
      int waited;
      waited = 0;
      while ((face_items.size() != 0 || req_valid || face_results_due.size() != 0)
             && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(negedge clock);
   endtask

   function automatic void set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 60; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 60; end
         default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
      endcase
   endfunction

   task automatic push_item(input logic [1:0] op, input logic [ROW_W-1:0] row,
                            input id_set_type ids, input logic [STEP_W-1:0] step,
                            input logic [VALUE_W-1:0] value);
      req_type it;
      it.op = op;
      it.row = row;
      it.id_0 = ids[0];
      it.id_1 = ids[1];
      it.id_2 = ids[2];
      it.id_3 = ids[3];
      it.step = step;
      it.load_value = value;
      face_items.push_back(it);
      // out-of-range value loads are ignored by the block; leave them out of the count
      if (!(op == OP_LOAD_VALUE && step > STEPS)) gen_count++;
   endtask

   // Unused fields carry random bits so the block must ignore them.
   task automatic push_ids(input int row, input id_set_type ids);
      push_item(OP_LOAD_IDS, ROW_W'(row), ids, STEP_W'($urandom), $urandom);
   endtask

   task automatic push_value(input int row, input int col, input logic [VALUE_W-1:0] value);
      push_item(OP_LOAD_VALUE, ROW_W'(row), {$urandom, $urandom, $urandom, $urandom},
                STEP_W'(col), value);
   endtask

   task automatic push_begin(input int step);
      push_item(OP_BEGIN_STEP, ROW_W'($urandom), {$urandom, $urandom, $urandom, $urandom},
                STEP_W'(step), $urandom);
   endtask

   task automatic push_query(input id_set_type ids);
      push_item(OP_QUERY, ROW_W'($urandom), ids, STEP_W'($urandom), $urandom);
   endtask

   function automatic id_set_type ids4(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                                       input logic [ID_W-1:0] c, input logic [ID_W-1:0] d);
      return {d, c, b, a};
   endfunction

   // Mostly a small pool so rows share ids and near misses happen.
   function automatic logic [ID_W-1:0] rand_id();
      if ($urandom_range(99) < 70) return ID_W'($urandom_range(0, 15));
      return $urandom & 32'h7FFF_FFFF;
   endfunction

   function automatic id_set_type shuffle_ids(input id_set_type s);
      id_set_type t;
      logic [ID_W-1:0] tmp;
      int j;
      t = s;
      for (int k = NODES - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = t[k];
         t[k] = t[j];
         t[j] = tmp;
      end
      return t;
   endfunction

   function automatic id_set_type make_face_row();
      id_set_type s;
      int used;
      used = $urandom_range(1, NODES);
      for (int k = 0; k < NODES; k++) s[k] = (k < used) ? rand_id() : UNUSED_SLOT;
      return shuffle_ids(s);
   endfunction

   // Fill every searched row, and its value in every column a pass may select.
   task automatic load_faces(input int fc, input bit [STEPS:0] cols_used);
      for (int r = 0; r < fc; r++) begin
         gen_rows[r] = make_face_row();
         push_ids(r, gen_rows[r]);
      end
      for (int c = 0; c <= STEPS; c++) begin
         if (cols_used[c]) begin
            for (int r = 0; r < fc; r++) push_value(r, c, $urandom);
         end
      end
   endtask

   // Mostly reordered copies of loaded rows, then near misses and random noise.
   task automatic push_face_queries(input int fc, input int count);
      id_set_type q;
      int k;
      int r;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         r = (fc != 0) ? $urandom_range(0, fc - 1) : 0;
         if (fc != 0 && k < 75) begin
            q = shuffle_ids(gen_rows[r]);
         end else if (fc != 0 && k < 88) begin
            q = shuffle_ids(gen_rows[r]);
            q[$urandom_range(0, NODES - 1)] = rand_id();
         end else begin
            q = make_face_row();
         end
         // rewrite a searched row now and then while the pass runs
         if (fc != 0 && $urandom_range(99) < 6) begin
            gen_rows[r] = make_face_row();
            push_ids(r, gen_rows[r]);
         end
         push_query(q);
      end
   endtask

   task automatic run_mixed_phase(input int ph);
      int fc;
      int start;
      int passes;
      int cursor;
      int step;
      int col;
      bit ready;
      bit [STEPS:0] cols_used;
      int pass_steps [$];
      cursor = last_seen_step;
      set_idling(ph % 4);
      fc = (ph % 6 == 5) ? 0 : $urandom_range(1, 12);
      ready = (ph % 5 != 3);
      // start at zero once: every step then lands past the last column
      start = (ph == 1) ? 0 : cursor + 1 + $urandom_range(0, 2);
      passes = (ph == PRESSURE_PHASE) ? 4 : $urandom_range(2, 5);
      cols_used = '0;
      for (int p = 0; p < passes; p++) begin
         if ($urandom_range(99) < 15) begin
            // stale step: closes the pass and changes nothing else
            step = cursor - $urandom_range(0, 2);
         end else begin
            step = cursor + $urandom_range(1, 3);
            cursor = step;
         end
         pass_steps.push_back(step);
         col = step - start;
         if (col >= 0 && col <= STEPS) cols_used[col] = 1'b1;
      end
      configure(fc, start, ready);
      if (ph == PRESSURE_PHASE) hold_request = 1'b1;
      load_faces(fc, cols_used);
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(2))
            0: push_ids($urandom_range(fc, FACES - 1), make_face_row());
            1: push_value($urandom_range(0, FACES - 1), $urandom_range(0, STEPS), $urandom);
            default: push_value($urandom_range(0, FACES - 1), $urandom_range(STEPS + 1, 65535),
                                $urandom);
         endcase
      end
      foreach (pass_steps[p]) begin
         push_begin(pass_steps[p]);
         push_face_queries(fc, (ph == PRESSURE_PHASE) ? 20 : $urandom_range(4, 16));
      end
      settle();
   endtask

   // Face count at or past the table size: walk the rows in order so the scan never
   // leaves the loaded rows. The two passes select columns zero and one.
   task automatic run_wide_phase(input int ph, input int face_total);
      int cursor;
      cursor = last_seen_step;
      set_idling(ph % 4);
      configure(face_total, cursor + 1, 1'b1);
      load_faces(4, (STEPS+1)'(3));
      repeat (2) begin
         cursor++;
         push_begin(cursor);
         for (int r = 0; r < 4; r++) push_query(shuffle_ids(gen_rows[r]));
      end
      settle();
   endtask

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int fc;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: table not ready, loads at the extremes, one ignored column.
      set_idling(0);
      configure(3, 20, 1'b0);
      push_query(ids4(1, 2, 3, 4));
      push_begin(12);
      push_ids(0, ids4(32'h7FFF_FFFF, 0, 1, 2));
      push_ids(1, ids4(5, 6, UNUSED_SLOT, UNUSED_SLOT));
      push_ids(2, ids4(9, UNUSED_SLOT, UNUSED_SLOT, UNUSED_SLOT));
      push_value(0, 0, 32'h8000_0000);
      push_value(1, 0, 32'h7FFF_FFFF);
      push_value(2, 0, 32'hFFFF_FFFF);
      push_value(0, STEPS, 32'd123);
      push_value(1, STEPS, 32'hDEAD_BEEF);
      push_value(2, STEPS, 32'd0);
      push_value(FACES - 1, STEPS + 1, 32'h5A5A_5A5A);
      settle();

      // Directed: ready table, stale and below-start steps, hits at and past the start.
      configure(3, 20, 1'b1);
      push_begin(15);
      push_query(ids4(1, 2, 3, 4));
      push_begin(15);
      push_begin(20);
      push_query(ids4(2, 1, 0, 32'h7FFF_FFFF));
      push_query(ids4(32'h7FFF_FFFF, 0, 1, 2));
      push_query(ids4(9, UNUSED_SLOT, 5, 6));
      push_query(ids4(9, UNUSED_SLOT, UNUSED_SLOT, UNUSED_SLOT));
      push_begin(20 + STEPS);
      push_query(ids4(UNUSED_SLOT, 9, 0, 0));
      push_query(ids4(6, 5, UNUSED_SLOT, UNUSED_SLOT));
      push_begin(21 + STEPS);
      push_query(ids4(6, 5, UNUSED_SLOT, UNUSED_SLOT));
      settle();

      // Random phases rotate the idling mix; every seventh one runs a huge face count.
      while (gen_count < ITEM_GOAL) begin
         if (phase % 7 == 6) run_wide_phase(phase, (phase % 14 == 6) ? FACES : 2047);
         else run_mixed_phase(phase);
         phase++;
      end

      // Last pass at the top step, which maps to column zero.
      set_idling(3);
      fc = $urandom_range(1, 6);
      configure(fc, 65535, 1'b1);
      load_faces(fc, (STEPS+1)'(1));
      push_begin(65535);
      push_face_queries(fc, 12);
      settle();

      if (face_results_due.size() != 0) begin
         $error("%0d expected results never arrived", face_results_due.size());
         mismatches++;
      end
      $display("Covered %0d request transfers over %0d phases with stalls and a long hold-off.",
               transfers, phase + 3);
      $display("Checked %0d lookups: %0d hits, %0d misses, %0d with the pass closed.",
               checked, hits, misses, skips);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
